[sv/aes_pkg.sv]
// ----------------------------------------------------------------------------
// AES package
// Shared types, substitution tables and round helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package aes_pkg;

  localparam int KeyWords     = 60;
  localparam int KeyIdxW      = 6;
  localparam int NumCfgRegs   = 5;
  localparam int CfgIdxW      = 3;

  localparam logic [CfgIdxW-1:0] REG_KEY0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY3 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KSIZE = 3'd4;

  localparam logic [1:0] KSIZE_128 = 2'd0;
  localparam logic [1:0] KSIZE_192 = 2'd1;

  localparam logic OP_ENCRYPT = 1'b0;

  typedef struct packed {
    logic        operation;
    logic [63:0] block_hi;
    logic [63:0] block_lo;
  } aes_in_t;

  typedef struct packed {
    logic [63:0] result_hi;
    logic [63:0] result_lo;
  } aes_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] index;
    logic [63:0]        data;
  } aes_cfg_t;

  // controller to datapath
  typedef struct packed {
    logic               ks_init;    // load key words, reset expansion
    logic               ks_step;    // store or expand one key word
    logic               blk_load;   // capture block, start at first key
    logic               rnd_step;   // run one round
    logic               key_rd;     // read key word from store
    logic [KeyIdxW-1:0] key_addr;
    logic               last;       // final round
    logic               res_load;
  } aes_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [3:0] nr;
    logic       ks_done;
  } aes_sts_t;

  function automatic logic [7:0] sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
    };
    return t[a];
  endfunction

  function automatic logic [7:0] inv_sbox(input logic [7:0] a);
    logic [7:0] t [256];
    t = '{
      8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
      8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
      8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
      8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
      8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
      8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
      8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
      8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
      8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
      8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
      8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
      8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
      8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
      8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
      8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
      8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
    };
    return t[a];
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
  endfunction

endpackage
`default_nettype wire

[sv/aes_block_cipher.sv]
// ----------------------------------------------------------------------------
// AES block cipher
// Encrypts or decrypts one 128-bit block with a configured 128/192/256 key.
// ----------------------------------------------------------------------------
// A block is taken when start is high and busy low. Each round, including
// the initial key addition, takes four reads of the single port round key
// store, key assembly and the round itself. The first block after reset or
// any key or key size register write first expands the key. The result
// is shown for one cycle with done and cannot be stalled.
`default_nettype none
module aes_block_cipher
  import aes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire aes_in_t  data_in,
  output logic          done,
  output aes_out_t      data_out,
  input  wire logic     cfg_valid,
  output logic          cfg_ready,
  input  wire aes_cfg_t cfg
);

  aes_cmd_t cmd;
  aes_sts_t sts;
  logic     cfg_we;

  assign cfg_ready = 1'b1;
  assign cfg_we = cfg_valid && cfg.index < CfgIdxW'(NumCfgRegs);

  aes_ctrl u_ctrl (
    .clk, .rst, .cfg_we, .start,
    .operation(data_in.operation),
    .sts, .cmd, .busy, .done
  );

  aes_datapath u_dp (
    .clk, .rst, .cfg, .cfg_we,
    .blk_in(data_in), .cmd, .sts,
    .blk_out(data_out)
  );

  a_one_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.rnd_step && cmd.ks_step)) else $error("round during key expansion");
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("done while idle");
  a_no_load_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.blk_load |-> !busy) else $error("block load while busy");

endmodule
`default_nettype wire

[sv/aes_datapath.sv]
// ----------------------------------------------------------------------------
// AES datapath
// Key schedule, round key store and iterative round unit.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_datapath
  import aes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire aes_cfg_t cfg,
  input  wire logic     cfg_we,
  input  wire aes_in_t  blk_in,
  input  wire aes_cmd_t cmd,
  output aes_sts_t      sts,
  output aes_out_t      blk_out
);

  localparam int AW = KeyIdxW;

  logic [63:0] key0, key1, key2, key3;
  logic [1:0]  key_size;
  logic [3:0]  nk;

  logic [31:0] rk_mem [KeyWords];
  logic [31:0] rk_rd;

  // key schedule: sliding window of last nk words
  logic [31:0] win [8];
  logic [AW-1:0] ks_idx;
  logic [2:0]  ks_mod;
  logic [7:0]  rcon;
  logic [31:0] ks_t, ks_new, ks_prev, ks_old;

  logic        op;
  logic [127:0] st;
  logic [127:0] rnd_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      key0 <= '0;
      key1 <= '0;
      key2 <= '0;
      key3 <= '0;
      key_size <= KSIZE_128;
    end else if (cfg_we) begin
      case (cfg.index)
        REG_KEY0: key0 <= cfg.data;
        REG_KEY1: key1 <= cfg.data;
        REG_KEY2: key2 <= cfg.data;
        REG_KEY3: key3 <= cfg.data;
        REG_KSIZE: key_size <= cfg.data[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (key_size)
      KSIZE_128: nk = 4'd4;
      KSIZE_192: nk = 4'd6;
      default:   nk = 4'd8;
    endcase
  end

  assign sts.nr = nk + 4'd6;

  assign ks_prev = win[3'(nk - 4'd1)];
  assign ks_old  = win[0];

  always_comb begin
    ks_t = ks_prev;
    if (ks_mod == 3'd0) begin
      ks_t = sub_word({ks_prev[23:0], ks_prev[31:24]}) ^ {rcon, 24'h0};
    end else if (nk == 4'd8 && ks_mod == 3'd4) begin
      ks_t = sub_word(ks_prev);
    end
    ks_new = ks_old ^ ks_t;
  end

  assign sts.ks_done = (ks_idx == AW'(4 * (32'(nk) + 7)));

  always_ff @(posedge clk) begin
    if (cmd.ks_init) begin
      win[0] <= key0[63:32];
      win[1] <= key0[31:0];
      win[2] <= key1[63:32];
      win[3] <= key1[31:0];
      win[4] <= key2[63:32];
      win[5] <= key2[31:0];
      win[6] <= key3[63:32];
      win[7] <= key3[31:0];
      ks_idx <= '0;
      ks_mod <= '0;
      rcon   <= 8'h8d;
    end else if (cmd.ks_step) begin
      if (ks_idx < AW'(nk)) begin
        rk_mem[ks_idx] <= win[ks_idx[2:0]];
      end else begin
        rk_mem[ks_idx] <= ks_new;
        for (int i = 0; i < 7; i++) begin
          if (i + 1 < int'(nk)) win[i] <= win[i+1];
        end
        win[nk[2:0] - 3'd1] <= ks_new;
        if (ks_mod == 3'd0) rcon <= xt(rcon);
        ks_mod <= (ks_mod == 3'(nk - 4'd1)) ? 3'd0 : ks_mod + 3'd1;
      end
      if (ks_idx == AW'(nk) - AW'(1)) begin
        ks_mod <= 3'd0;
        rcon   <= 8'h01;
      end
      ks_idx <= ks_idx + AW'(1);
    end
  end

  // round key word read, 4 words per round through a 128-bit assembly reg
  always_ff @(posedge clk) begin
    if (cmd.key_rd) rk_rd <= rk_mem[cmd.key_addr];
  end

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] b);
    logic [7:0] a2, a4, a8, p;
    a2 = xt(a);
    a4 = xt(a2);
    a8 = xt(a4);
    p = (b[0] ? a : 8'h0) ^ (b[1] ? a2 : 8'h0) ^ (b[2] ? a4 : 8'h0) ^ (b[3] ? a8 : 8'h0);
    return p;
  endfunction

  // round key: collected into a 128-bit register over four reads
  logic [127:0] rkey;
  logic         rk_shift;
  always_ff @(posedge clk) begin
    rk_shift <= cmd.key_rd;
    if (rk_shift) rkey <= {rkey[95:0], rk_rd};
  end

  // one round: sub, shift, mix, add key; decrypt: inv shift, inv sub, add key, inv mix (no mix in last round)
  always_comb begin
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [7:0] a0, a1, a2, a3, al;
    a0 = '0;
    a1 = '0;
    a2 = '0;
    a3 = '0;
    al = '0;
    for (int i = 0; i < 16; i++) s[i] = st[127 - 8*i -: 8];
    if (op == OP_ENCRYPT) begin
      for (int i = 0; i < 16; i++) s[i] = sbox(s[i]);
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*c+r] = s[4*((c+r)%4)+r];
      if (!cmd.last) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          al = a0 ^ a1 ^ a2 ^ a3;
          t[4*c]   = a0 ^ al ^ xt(a0 ^ a1);
          t[4*c+1] = a1 ^ al ^ xt(a1 ^ a2);
          t[4*c+2] = a2 ^ al ^ xt(a2 ^ a3);
          t[4*c+3] = a3 ^ al ^ xt(a3 ^ a0);
        end
      end
      for (int i = 0; i < 16; i++) t[i] = t[i] ^ rkey[127 - 8*i -: 8];
    end else begin
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++) t[4*((c+r)%4)+r] = s[4*c+r];
      for (int i = 0; i < 16; i++) t[i] = inv_sbox(t[i]) ^ rkey[127 - 8*i -: 8];
      if (!cmd.last) begin
        for (int c = 0; c < 4; c++) begin
          a0 = t[4*c]; a1 = t[4*c+1]; a2 = t[4*c+2]; a3 = t[4*c+3];
          t[4*c]   = gm(a0,4'd14) ^ gm(a1,4'd11) ^ gm(a2,4'd13) ^ gm(a3,4'd9);
          t[4*c+1] = gm(a1,4'd14) ^ gm(a2,4'd11) ^ gm(a3,4'd13) ^ gm(a0,4'd9);
          t[4*c+2] = gm(a2,4'd14) ^ gm(a3,4'd11) ^ gm(a0,4'd13) ^ gm(a1,4'd9);
          t[4*c+3] = gm(a3,4'd14) ^ gm(a0,4'd11) ^ gm(a1,4'd13) ^ gm(a2,4'd9);
        end
      end
    end
    for (int i = 0; i < 16; i++) rnd_out[127 - 8*i -: 8] = t[i];
  end

  always_ff @(posedge clk) begin
    if (cmd.blk_load) begin
      op <= blk_in.operation;
      st <= {blk_in.block_hi, blk_in.block_lo};
    end else if (cmd.res_load) begin
      st <= st ^ rkey;
    end else if (cmd.rnd_step) begin
      st <= rnd_out;
    end
  end

  assign blk_out.result_hi = st[127:64];
  assign blk_out.result_lo = st[63:0];

endmodule
`default_nettype wire

[sv/aes_ctrl.sv]
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion, round key fetch and rounds.
// ----------------------------------------------------------------------------
`default_nettype none
module aes_ctrl
  import aes_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     cfg_we,
  input  wire logic     start,
  input  wire logic     operation,
  input  wire aes_sts_t sts,
  output aes_cmd_t      cmd,
  output logic          busy,
  output logic          done
);

  localparam int AW = KeyIdxW;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_KINIT = 6'b000010,
    S_KEXP  = 6'b000100,
    S_FETCH = 6'b001000,
    S_ROUND = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state, state_next;
  logic   keys_ready;
  logic   op;
  logic   first;       // initial key addition pending
  logic [3:0] rnd;     // rounds done
  logic [2:0] fcnt;    // fetch cycle 0..5
  logic [3:0] kround;

  // round index of key in use
  always_comb begin
    if (first) kround = (op == OP_ENCRYPT) ? 4'd0 : sts.nr;
    else kround = (op == OP_ENCRYPT) ? rnd + 4'd1 : sts.nr - rnd - 4'd1;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (start) state_next = keys_ready ? S_FETCH : S_KINIT;
      S_KINIT: state_next = S_KEXP;
      S_KEXP:  if (sts.ks_done) state_next = S_FETCH;
      S_FETCH: if (fcnt == 3'd5) state_next = S_ROUND;
      S_ROUND: state_next = (!first && rnd + 4'd1 == sts.nr) ? S_DONE : S_FETCH;
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      keys_ready <= 1'b0;
      fcnt <= '0;
      rnd <= '0;
      first <= 1'b0;
      op <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_IDLE && start) begin
        op <= operation;
        first <= 1'b1;
        rnd <= '0;
        fcnt <= '0;
      end
      if (state == S_KEXP && sts.ks_done) keys_ready <= 1'b1;
      if (cfg_we) keys_ready <= 1'b0;
      if (state == S_FETCH) fcnt <= fcnt + 3'd1;
      if (state == S_ROUND) begin
        fcnt <= '0;
        if (first) first <= 1'b0;
        else rnd <= rnd + 4'd1;
      end
    end
  end

  always_comb begin
    cmd = '0;
    cmd.blk_load = (state == S_IDLE) && start;
    cmd.ks_init  = (state == S_KINIT);
    cmd.ks_step  = (state == S_KEXP) && !sts.ks_done;
    cmd.key_rd   = (state == S_FETCH) && (fcnt < 3'd4);
    cmd.key_addr = AW'({kround, 2'b00} + {4'd0, fcnt[1:0]});
    cmd.res_load = (state == S_ROUND) && first;
    cmd.rnd_step = (state == S_ROUND) && !first;
    cmd.last     = (rnd + 4'd1 == sts.nr);
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_DONE);

endmodule
`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// AES block cipher testbench
// Writes 128, 192 and 256 bit keys through the register channel and runs
// encrypt and decrypt blocks. Known test vectors come first, then random
// blocks in bursts under changing keys. A behavioral cipher in this module
// predicts every result. A monitor compares each done strobe with the
// oldest predicted block.
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
  import aes_pkg::*;

  localparam logic [1:0] KSIZE_256 = 2'd2;
  localparam logic [1:0] KSIZE_ALT = 2'd3;
  localparam logic       OP_DECRYPT = 1'b1;
  localparam int         STALL_LIMIT = 4000;
  localparam int         NUM_RANDOM = 800;

  typedef struct {
    bit          rekey;
    bit          stray;
    logic [1:0]  ksize;
    logic [63:0] key [4];
    logic        op;
    logic [63:0] hi;
    logic [63:0] lo;
    bit          known;
    logic [63:0] res_hi;
    logic [63:0] res_lo;
  } vector_t;

  logic     clk;
  logic     rst;
  logic     start;
  logic     busy;
  aes_in_t  data_in;
  logic     done;
  aes_out_t data_out;
  logic     cfg_valid;
  logic     cfg_ready;
  aes_cfg_t cfg;

  logic [7:0]  fwd_tab [256];
  logic [7:0]  inv_tab [256];
  logic [63:0] key_reg [4];
  logic [1:0]  ksize_reg;
  logic [31:0] rkey [60];
  bit          rkey_valid;
  logic [7:0]  st [16];

  aes_out_t    block_q [$];
  aes_out_t    last_block;
  vector_t     vectors [$];
  int          errors;
  int          idle_cycles;

  aes_block_cipher i_dut (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .busy     (busy),
    .data_in  (data_in),
    .done     (done),
    .data_out (data_out),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg      (cfg)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [7:0] dbl(input logic [7:0] v);
    return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = dbl(a);
    end
    return p;
  endfunction

  function automatic logic [7:0] rol8(input logic [7:0] v, input int k);
    logic [15:0] w;
    w = {v, v} << k;
    return w[15:8];
  endfunction

  function void build_tables();
    logic [7:0] inv;
    logic [7:0] s;
    for (int x = 0; x < 256; x++) begin
      inv = 8'h00;
      for (int y = 1; y < 256; y++)
        if (gmul(x[7:0], y[7:0]) == 8'h01) inv = y[7:0];
      s = inv ^ rol8(inv, 1) ^ rol8(inv, 2) ^ rol8(inv, 3) ^ rol8(inv, 4) ^ 8'h63;
      fwd_tab[x] = s;
      inv_tab[s] = x[7:0];
    end
  endfunction

  function automatic int key_words();
    return (ksize_reg == KSIZE_128) ? 4 : (ksize_reg == KSIZE_192) ? 6 : 8;
  endfunction

  function automatic logic [31:0] sub32(input logic [31:0] w);
    return {fwd_tab[w[31:24]], fwd_tab[w[23:16]], fwd_tab[w[15:8]], fwd_tab[w[7:0]]};
  endfunction

  function void expand_key();
    int nk;
    logic [31:0] t;
    logic [7:0] rc;
    nk = key_words();
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      rkey[i] = (i % 2 == 0) ? key_reg[i/2][63:32] : key_reg[i/2][31:0];
    for (int i = nk; i < 4 * (nk + 7); i++) begin
      t = rkey[i-1];
      if (i % nk == 0) begin
        t = sub32({t[23:0], t[31:24]}) ^ {rc, 24'h0};
        rc = dbl(rc);
      end else if (nk == 8 && i % nk == 4) begin
        t = sub32(t);
      end
      rkey[i] = rkey[i-nk] ^ t;
    end
    rkey_valid = 1'b1;
  endfunction

  function void add_round_key(input int r);
    logic [31:0] w;
    for (int c = 0; c < 4; c++) begin
      w = rkey[(4 * r + c) % 60];
      for (int k = 0; k < 4; k++) st[4*c+k] ^= w[31-8*k -: 8];
    end
  endfunction

  function void shift_state(input bit inverse);
    logic [7:0] t [16];
    t = st;
    for (int c = 0; c < 4; c++)
      for (int r = 0; r < 4; r++)
        if (inverse) st[4*((c+r)%4)+r] = t[4*c+r];
        else st[4*c+r] = t[4*((c+r)%4)+r];
  endfunction

  function void mix_state(input bit inverse);
    logic [7:0] a0, a1, a2, a3, all;
    for (int c = 0; c < 4; c++) begin
      a0 = st[4*c]; a1 = st[4*c+1]; a2 = st[4*c+2]; a3 = st[4*c+3];
      if (inverse) begin
        st[4*c]   = gmul(a0, 8'd14) ^ gmul(a1, 8'd11) ^ gmul(a2, 8'd13) ^ gmul(a3, 8'd9);
        st[4*c+1] = gmul(a1, 8'd14) ^ gmul(a2, 8'd11) ^ gmul(a3, 8'd13) ^ gmul(a0, 8'd9);
        st[4*c+2] = gmul(a2, 8'd14) ^ gmul(a3, 8'd11) ^ gmul(a0, 8'd13) ^ gmul(a1, 8'd9);
        st[4*c+3] = gmul(a3, 8'd14) ^ gmul(a0, 8'd11) ^ gmul(a1, 8'd13) ^ gmul(a2, 8'd9);
      end else begin
        all = a0 ^ a1 ^ a2 ^ a3;
        st[4*c]   = a0 ^ all ^ dbl(a0 ^ a1);
        st[4*c+1] = a1 ^ all ^ dbl(a1 ^ a2);
        st[4*c+2] = a2 ^ all ^ dbl(a2 ^ a3);
        st[4*c+3] = a3 ^ all ^ dbl(a3 ^ a0);
      end
    end
  endfunction

  function automatic aes_out_t cipher_block(input aes_in_t blk);
    aes_out_t res;
    int nr;
    if (!rkey_valid) expand_key();
    nr = key_words() + 6;
    for (int i = 0; i < 8; i++) begin
      st[i]   = blk.block_hi[63-8*i -: 8];
      st[8+i] = blk.block_lo[63-8*i -: 8];
    end
    if (blk.operation == OP_ENCRYPT) begin
      add_round_key(0);
      for (int r = 1; r <= nr; r++) begin
        for (int i = 0; i < 16; i++) st[i] = fwd_tab[st[i]];
        shift_state(1'b0);
        if (r < nr) mix_state(1'b0);
        add_round_key(r);
      end
    end else begin
      add_round_key(nr);
      for (int r = nr - 1; r >= 0; r--) begin
        shift_state(1'b1);
        for (int i = 0; i < 16; i++) st[i] = inv_tab[st[i]];
        add_round_key(r);
        if (r > 0) mix_state(1'b1);
      end
    end
    for (int i = 0; i < 8; i++) begin
      res.result_hi[63-8*i -: 8] = st[i];
      res.result_lo[63-8*i -: 8] = st[8+i];
    end
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("ERROR %0t: %s expected %h got %h", $realtime, what, want, got);
    errors++;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg <= '{idx, value};
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: begin
        key_reg[idx] = value;
        rkey_valid = 1'b0;
      end
      REG_KSIZE: begin
        ksize_reg = value[1:0];
        rkey_valid = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic drain();
    start <= 1'b0;
    while (block_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    aes_in_t blk;
    blk = '{op, hi, lo};
    cfg_valid <= 1'b0;
    start <= 1'b1;
    data_in <= blk;
    do @(posedge clk); while (busy);
    last_block = cipher_block(blk);
    block_q.push_back(last_block);
  endtask

  task automatic add_vector(input bit rekey, input bit stray, input logic [1:0] ksize,
                            input logic [63:0] k0, input logic [63:0] k1,
                            input logic [63:0] k2, input logic [63:0] k3,
                            input logic op, input logic [63:0] hi, input logic [63:0] lo,
                            input bit known, input logic [63:0] rhi, input logic [63:0] rlo);
    vector_t v;
    v.rekey = rekey; v.stray = stray; v.ksize = ksize;
    v.key[0] = k0; v.key[1] = k1; v.key[2] = k2; v.key[3] = k3;
    v.op = op; v.hi = hi; v.lo = lo;
    v.known = known; v.res_hi = rhi; v.res_lo = rlo;
    vectors.push_back(v);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (block_q.size() == 0) begin
        report_mismatch("result with no block pending", '0, data_out.result_hi);
      end else begin
        aes_out_t want;
        want = block_q.pop_front();
        if (data_out.result_hi !== want.result_hi)
          report_mismatch("result_hi", want.result_hi, data_out.result_hi);
        if (data_out.result_lo !== want.result_lo)
          report_mismatch("result_lo", want.result_lo, data_out.result_lo);
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [63:0] pt_hi, pt_lo, k0, k1, k2, k3, ones;
    int sent, phase_len, burst;
    aes_out_t want;
    rst = 1'b1;
    start = 1'b0;
    data_in = '0;
    cfg_valid = 1'b0;
    cfg = '0;
    errors = 0;
    idle_cycles = 0;
    key_reg = '{default: '0};
    ksize_reg = KSIZE_128;
    rkey = '{default: '0};
    rkey_valid = 1'b0;
    build_tables();

    pt_hi = 64'h0011223344556677; pt_lo = 64'h8899aabbccddeeff;
    k0 = 64'h0001020304050607; k1 = 64'h08090a0b0c0d0e0f;
    k2 = 64'h1011121314151617; k3 = 64'h18191a1b1c1d1e1f;
    ones = '1;
    add_vector(0, 0, KSIZE_128, 0, 0, 0, 0, OP_ENCRYPT, 0, 0,
               1, 64'h66e94bd4ef8a2c3b, 64'h884cfa59ca342b2e);
    add_vector(1, 0, KSIZE_128, k0, k1, 0, 0, OP_ENCRYPT, pt_hi, pt_lo,
               1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_vector(0, 0, KSIZE_128, 0, 0, 0, 0, OP_DECRYPT,
               64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a, 1, pt_hi, pt_lo);
    add_vector(0, 1, KSIZE_128, 0, 0, 0, 0, OP_ENCRYPT, pt_hi, pt_lo,
               1, 64'h69c4e0d86a7b0430, 64'hd8cdb78070b4c55a);
    add_vector(1, 0, KSIZE_192, k0, k1, k2, 0, OP_ENCRYPT, pt_hi, pt_lo,
               1, 64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191);
    add_vector(0, 0, KSIZE_192, 0, 0, 0, 0, OP_DECRYPT,
               64'hdda97ca4864cdfe0, 64'h6eaf70a0ec0d7191, 1, pt_hi, pt_lo);
    add_vector(1, 0, KSIZE_256, k0, k1, k2, k3, OP_ENCRYPT, pt_hi, pt_lo,
               1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    add_vector(0, 0, KSIZE_256, 0, 0, 0, 0, OP_DECRYPT,
               64'h8ea2b7ca516745bf, 64'heafc49904b496089, 1, pt_hi, pt_lo);
    add_vector(1, 0, KSIZE_ALT, k0, k1, k2, k3, OP_ENCRYPT, pt_hi, pt_lo,
               1, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    add_vector(0, 0, KSIZE_ALT, 0, 0, 0, 0, OP_ENCRYPT, ones, ones, 0, 0, 0);
    add_vector(0, 0, KSIZE_ALT, 0, 0, 0, 0, OP_DECRYPT, ones, ones, 0, 0, 0);
    add_vector(1, 0, KSIZE_128, ones, ones, 64'h5a5a5a5a5a5a5a5a, 64'ha5a5a5a5a5a5a5a5,
               OP_ENCRYPT, 0, 0, 0, 0, 0);
    add_vector(0, 0, KSIZE_128, 0, 0, 0, 0, OP_DECRYPT, ones, ones, 0, 0, 0);
    add_vector(1, 0, KSIZE_192, ones, ones, ones, 0, OP_ENCRYPT, ones, ones, 0, 0, 0);
    add_vector(0, 0, KSIZE_192, 0, 0, 0, 0, OP_DECRYPT, 0, 0, 0, 0, 0);
    add_vector(1, 0, KSIZE_256, ones, ones, ones, ones, OP_ENCRYPT, 0, ones, 0, 0, 0);
    add_vector(0, 0, KSIZE_256, 0, 0, 0, 0, OP_DECRYPT, ones, 0, 0, 0, 0);
    add_vector(1, 0, KSIZE_256, 0, 0, 0, 0, OP_ENCRYPT, ones, ones, 0, 0, 0);

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (vectors[n]) begin
      if (vectors[n].rekey || vectors[n].stray) drain();
      if (vectors[n].rekey) begin
        write_reg(REG_KEY0, vectors[n].key[0]);
        write_reg(REG_KEY1, vectors[n].key[1]);
        write_reg(REG_KEY2, vectors[n].key[2]);
        write_reg(REG_KEY3, vectors[n].key[3]);
        write_reg(REG_KSIZE, {62'd0, vectors[n].ksize});
      end
      if (vectors[n].stray)
        for (int idx = REG_KSIZE + 1; idx < 2 ** CfgIdxW; idx++)
          write_reg(CfgIdxW'(idx), ones);
      send_block(vectors[n].op, vectors[n].hi, vectors[n].lo);
      if (vectors[n].known) begin
        want = '{vectors[n].res_hi, vectors[n].res_lo};
        if (block_q[$].result_hi !== want.result_hi)
          report_mismatch($sformatf("known vector %0d predicted hi", n),
                          want.result_hi, block_q[$].result_hi);
        if (block_q[$].result_lo !== want.result_lo)
          report_mismatch($sformatf("known vector %0d predicted lo", n),
                          want.result_lo, block_q[$].result_lo);
        block_q[$] = want;
      end
    end

    sent = 0;
    while (sent < NUM_RANDOM) begin
      drain();
      for (int r = 0; r < 4; r++) begin
        if ($urandom_range(0, 1)) begin
          case ($urandom_range(0, 5))
            0: write_reg(CfgIdxW'(r), '0);
            1: write_reg(CfgIdxW'(r), ones);
            default: write_reg(CfgIdxW'(r), {$urandom, $urandom});
          endcase
        end
      end
      if ($urandom_range(0, 5) == 0)
        write_reg(CfgIdxW'($urandom_range(REG_KSIZE + 1, 7)), ones);
      write_reg(REG_KSIZE, {$urandom, $urandom_range(0, 3)});
      phase_len = $urandom_range(20, 120);
      burst = $urandom_range(1, 30);
      for (int i = 0; i < phase_len && sent < NUM_RANDOM; i++) begin
        if ($urandom_range(0, 3) == 0)
          send_block(1'(~last_block.result_hi[0] | $urandom_range(0, 1)),
                     last_block.result_hi, last_block.result_lo);
        else
          send_block(1'($urandom_range(0, 1)), {$urandom, $urandom}, {$urandom, $urandom});
        sent++;
        burst--;
        if (burst == 0) begin
          if ($urandom_range(0, 30) == 0) begin
            drain();
          end else begin
            start <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
          end
          burst = $urandom_range(1, 30);
        end
      end
    end

    drain();
    repeat (20) @(posedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

[filelist.f]
sv/aes_pkg.sv
sv/aes_datapath.sv
sv/aes_ctrl.sv
sv/aes_block_cipher.sv
tb/tb.sv
